// ----- hw/rtl/urf_pkg.sv -----
package urf_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 16;

  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RECV  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [BYTE_W-1:0] OFS_DATA   = 8'd0;
  localparam logic [BYTE_W-1:0] OFS_STATUS = 8'd1;
  localparam logic [BYTE_W-1:0] OFS_CTRL   = 8'd2;

  localparam logic [BYTE_W-1:0] ST_RX_NOT_EMPTY = 8'h01;
  localparam logic [BYTE_W-1:0] ST_TX_EMPTY     = 8'h02;
  localparam logic [BYTE_W-1:0] ST_OVERRUN      = 8'h04;

  localparam int CR_RX_IRQ_BIT = 0;
  localparam int CR_TX_IRQ_BIT = 1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic take;
    logic pop;
    logic load_pop;
  } cmd_t;

  typedef struct packed {
    logic pop_req;
    logic out_full;
  } status_t;

endpackage

// ----- hw/rtl/urf_ctrl.sv -----
module urf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  input  urf_pkg::status_t stat,
  output urf_pkg::cmd_t    cmd
);
  import urf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign take = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && stat.pop_req) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.take     = 1'b0;
    cmd.pop      = 1'b0;
    cmd.load_pop = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = stat.out_full && out_stall;
        cmd.take = in_valid && !(stat.out_full && out_stall);
        cmd.pop  = in_valid && !(stat.out_full && out_stall) && stat.pop_req;
      end
      ST_POP: begin
        cmd.load_pop = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/urf_dpath.sv -----
module urf_dpath #(
  parameter int FIFO_DEPTH = urf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_offset,
  input  logic [7:0]       in_wdata,
  input  logic [7:0]       in_rx_char,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_rdata,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_data,
  output logic             out_irq,
  input  urf_pkg::cmd_t    cmd,
  output urf_pkg::status_t stat
);
  import urf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [BYTE_W-1:0] mem_q_r;

  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovr_r, ovr_nxt;
  logic [BYTE_W-1:0] ctrl_r, ctrl_nxt;
  logic              full_r, full_nxt;

  logic [BYTE_W-1:0] rdata_r, rdata_nxt;
  logic              txv_r, txv_nxt;
  logic [BYTE_W-1:0] txd_r, txd_nxt;
  logic              irq_r, irq_nxt;

  logic              is_read, is_write, is_recv;
  logic              fifo_full, push;
  logic [BYTE_W-1:0] reg_rdata;

  assign is_read   = in_func == FUNC_READ;
  assign is_write  = in_func == FUNC_WRITE;
  assign is_recv   = in_func == FUNC_RECV;
  assign fifo_full = count_r == FULL_COUNT;
  assign push      = cmd.take && is_recv && !fifo_full;

  assign stat.pop_req  = is_read && (in_offset == OFS_DATA) && (count_r != '0);
  assign stat.out_full = full_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    ovr_nxt    = ovr_r;
    ctrl_nxt   = ctrl_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (cmd.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
    if (cmd.take && is_recv && fifo_full) begin
      ovr_nxt = 1'b1;
    end
    if (cmd.take && is_write && in_offset == OFS_STATUS) begin
      ovr_nxt = 1'b0;
    end
    if (cmd.take && is_write && in_offset == OFS_CTRL) begin
      ctrl_nxt = in_wdata;
    end
  end

  always_comb begin
    reg_rdata = '0;
    if (is_read) begin
      unique case (in_offset)
        OFS_STATUS: begin
          reg_rdata = ST_TX_EMPTY
                    | ((count_r != '0) ? ST_RX_NOT_EMPTY : '0)
                    | (ovr_r ? ST_OVERRUN : '0);
        end
        OFS_CTRL: begin
          reg_rdata = ctrl_r;
        end
        default: begin
          reg_rdata = '0;
        end
      endcase
    end
  end

  always_comb begin
    rdata_nxt = rdata_r;
    txv_nxt   = txv_r;
    txd_nxt   = txd_r;
    irq_nxt   = irq_r;
    full_nxt  = full_r && out_stall;
    if (cmd.load_pop) begin
      rdata_nxt = mem_q_r;
      txv_nxt   = 1'b0;
      txd_nxt   = '0;
      irq_nxt   = (ctrl_r[CR_RX_IRQ_BIT] && count_r != '0) || ctrl_r[CR_TX_IRQ_BIT];
      full_nxt  = 1'b1;
    end else if (cmd.take && !stat.pop_req) begin
      rdata_nxt = reg_rdata;
      txv_nxt   = is_write && (in_offset == OFS_DATA);
      txd_nxt   = (is_write && (in_offset == OFS_DATA)) ? in_wdata : '0;
      irq_nxt   = (ctrl_nxt[CR_RX_IRQ_BIT] && count_nxt != '0) || ctrl_nxt[CR_TX_IRQ_BIT];
      full_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_rx_char;
    end
    if (cmd.pop) begin
      mem_q_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    txv_r   <= txv_nxt;
    txd_r   <= txd_nxt;
    irq_r   <= irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      ovr_r    <= 1'b0;
      ctrl_r   <= '0;
      full_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      ovr_r    <= ovr_nxt;
      ctrl_r   <= ctrl_nxt;
      full_r   <= full_nxt;
    end
  end

  assign out_valid    = full_r;
  assign out_rdata    = rdata_r;
  assign out_tx_valid = txv_r;
  assign out_tx_data  = txd_r;
  assign out_irq      = irq_r;

endmodule

// ----- hw/rtl/uart_rx_fifo_registers.sv -----
// UART register block with a receive FIFO.
// The input channel carries one item per transfer: a bus read, a bus write,
// a character received from the line or no operation, selected by in_func.
// The result channel returns exactly one result per item, in order, with
// read data, the transmit byte of a data register write and the interrupt level.
// A result appears in the cycle after its item is taken, except for a read
// of the data register with bytes queued, which is loaded via the ST_POP state.
// Items are taken one per cycle when the output is not stalled; a popping read
// holds the input while the FIFO memory read goes through its registered port.
// The output register lets the next item in while the current result is
// being taken, so back-to-back transfers run at full rate when not stalled.
// When the receiver stalls with a result pending, in_stall rises and holds
// the input until that result is transferred.
// Reset empties the FIFO, clears the overrun flag and the control byte and
// drops any pending result; the FIFO memory itself is not cleared.
module uart_rx_fifo_registers #(
  parameter int FIFO_DEPTH = urf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_offset,
  input  logic [7:0] in_wdata,
  input  logic [7:0] in_rx_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_data,
  output logic       out_irq
);
  import urf_pkg::*;

  cmd_t    cmd;
  status_t stat;

  urf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  urf_dpath #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_func),
    .in_offset   (in_offset),
    .in_wdata    (in_wdata),
    .in_rx_char  (in_rx_char),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_rdata   (out_rdata),
    .out_tx_valid(out_tx_valid),
    .out_tx_data (out_tx_data),
    .out_irq     (out_irq),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ----- hw/rtl/urf_checker.sv -----
module urf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_func,
  input logic [7:0] in_offset,
  input logic [7:0] in_wdata,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_rdata,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_data,
  input logic       out_irq
);
  import urf_pkg::*;

  logic in_take;

  assign in_take = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_rdata == '0)
    else $error("transmit result carries read data");

  a_ctrl_irq: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_func == FUNC_WRITE && in_offset == OFS_CTRL
      && in_wdata[CR_TX_IRQ_BIT] |=> out_valid && out_irq)
    else $error("irq missing after control write");

  a_status_tx: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_func == FUNC_READ && in_offset == OFS_STATUS
      |=> out_valid && out_rdata[1] && !out_tx_valid && out_tx_data == '0)
    else $error("status read result wrong");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind uart_rx_fifo_registers urf_checker u_urf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_func     (in_func),
  .in_offset   (in_offset),
  .in_wdata    (in_wdata),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_rdata   (out_rdata),
  .out_tx_valid(out_tx_valid),
  .out_tx_data (out_tx_data),
  .out_irq     (out_irq)
);
